### sv/rav_pkg.sv
// ----------------------------------------------------------------------------
// rav_pkg - shared definitions for the nonzero ring average
// Sample width, default ring depth and sequencer state encoding.
// ----------------------------------------------------------------------------
package rav_pkg;

   localparam int SAMPLE_W       = 12;
   localparam int RING_DEPTH_DEF = 10;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DIV_GO,
      ST_DIV_WAIT,
      ST_RESP
   } state_type;

endpackage

### sv/ring_average_nonzero_core.sv
// ----------------------------------------------------------------------------
// ring_average_nonzero_core - truncated mean of the nonzero ring entries
// Each sample overwrites the oldest of RING_DEPTH slots; the result is the
// truncated mean of all nonzero slots, or zero when every slot is zero.
// ----------------------------------------------------------------------------
// One item at a time: req_ready is high only while idle. After the transfer,
// one RAM read per slot through the single read port forms sum and count,
// then the divider forms one quotient bit per cycle; it is skipped when all
// slots are zero. The result then waits in its output register until taken.
// Slots are cleared at reset by a valid bit each, so no clearing pass is
// needed.
module ring_average_nonzero_core #(
   parameter int RING_DEPTH = rav_pkg::RING_DEPTH_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [rav_pkg::SAMPLE_W-1:0] req_sample,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [rav_pkg::SAMPLE_W-1:0] rsp_average
);

   import rav_pkg::*;

   localparam int IDX_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
   localparam int CNT_W = $clog2(RING_DEPTH + 1);
   localparam int SUM_W = SAMPLE_W + CNT_W;

   state_type             state_ff, state_in;
   logic [IDX_W-1:0]      wslot_ff, wslot_in;
   logic [RING_DEPTH-1:0] slot_vld_ff, slot_vld_in;
   logic [CNT_W-1:0]      scan_ff, scan_in;
   logic                  rd_ok_ff, rd_ok_in;
   logic [SUM_W-1:0]      sum_ff, sum_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic [SAMPLE_W-1:0]   avg_ff, avg_in;

   logic                  req_xfer;
   logic                  issue;
   logic                  div_start;
   logic                  div_done;
   logic [SAMPLE_W-1:0]   div_quo;
   logic [SAMPLE_W-1:0]   rd_data;
   logic                  scan_end;

   assign req_xfer = req_valid && req_ready;
   assign scan_end = (scan_ff == CNT_W'(RING_DEPTH));

   rav_ram #(
      .WIDTH (SAMPLE_W),
      .DEPTH (RING_DEPTH),
      .AW    (IDX_W)
   ) u_ram (
      .clock (clock),
      .we    (req_xfer),
      .waddr (wslot_ff),
      .wdata (req_sample),
      .raddr (scan_ff[IDX_W-1:0]),
      .rdata (rd_data)
   );

   rav_div #(
      .QUO_W (SAMPLE_W),
      .DEN_W (CNT_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (sum_ff),
      .divisor  (cnt_ff),
      .done     (div_done),
      .quotient (div_quo)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:     if (req_xfer) state_in = ST_SCAN;
         ST_SCAN:     if (scan_end) state_in = ST_DIV_GO;
         ST_DIV_GO:   state_in = (cnt_ff == '0) ? ST_RESP : ST_DIV_WAIT;
         ST_DIV_WAIT: if (div_done) state_in = ST_RESP;
         ST_RESP:     if (rsp_ready) state_in = ST_IDLE;
         default:     state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req_ready = (state_ff == ST_IDLE);
      rsp_valid = (state_ff == ST_RESP);
      issue     = (state_ff == ST_SCAN) && !scan_end;
      div_start = (state_ff == ST_DIV_GO) && (cnt_ff != '0);
   end

   // datapath
   always_comb begin
      wslot_in    = wslot_ff;
      slot_vld_in = slot_vld_ff;
      scan_in     = scan_ff;
      sum_in      = sum_ff;
      cnt_in      = cnt_ff;
      avg_in      = avg_ff;
      rd_ok_in    = issue && slot_vld_ff[scan_ff[IDX_W-1:0]];
      if (req_xfer) begin
         slot_vld_in[wslot_ff] = 1'b1;
         wslot_in = (wslot_ff == IDX_W'(RING_DEPTH - 1)) ? '0 : wslot_ff + IDX_W'(1);
         scan_in  = '0;
         sum_in   = '0;
         cnt_in   = '0;
      end
      if (issue) begin
         scan_in = scan_ff + CNT_W'(1);
      end
      // entry whose read was issued in the previous cycle
      if (state_ff == ST_SCAN && rd_ok_ff && rd_data != '0) begin
         sum_in = sum_ff + SUM_W'(rd_data);
         cnt_in = cnt_ff + CNT_W'(1);
      end
      if (state_ff == ST_DIV_GO && cnt_ff == '0) begin
         avg_in = '0;
      end
      if (state_ff == ST_DIV_WAIT && div_done) begin
         avg_in = div_quo;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         wslot_ff    <= '0;
         slot_vld_ff <= '0;
         scan_ff     <= '0;
         rd_ok_ff    <= 1'b0;
      end else begin
         state_ff    <= state_in;
         wslot_ff    <= wslot_in;
         slot_vld_ff <= slot_vld_in;
         scan_ff     <= scan_in;
         rd_ok_ff    <= rd_ok_in;
      end
      sum_ff <= sum_in;
      cnt_ff <= cnt_in;
      avg_ff <= avg_in;
   end

   assign rsp_average = avg_ff;

endmodule

### sv/rav_ram.sv
// ----------------------------------------------------------------------------
// rav_ram - generic single write port RAM
// One write and one read port, read data registered.
// ----------------------------------------------------------------------------
module rav_ram #(
   parameter int WIDTH = 12,
   parameter int DEPTH = 10,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

### sv/rav_div.sv
// ----------------------------------------------------------------------------
// rav_div - iterative restoring divider
// One quotient bit per cycle. The caller guarantees the quotient fits QUO_W
// bits, i.e. the upper DEN_W dividend bits are below the divisor.
// ----------------------------------------------------------------------------
module rav_div #(
   parameter int QUO_W = 12,
   parameter int DEN_W = 4
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic [QUO_W+DEN_W-1:0] dividend,
   input  logic [DEN_W-1:0]       divisor,
   output logic                   done,
   output logic [QUO_W-1:0]       quotient
);

   localparam int STEP_W = $clog2(QUO_W + 1);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [DEN_W-1:0]  rem_ff, rem_in;
   logic [QUO_W-1:0]  quo_ff, quo_in;
   logic [DEN_W:0]    trial;
   logic [DEN_W:0]    diff;

   always_comb begin
      trial   = {rem_ff, quo_ff[QUO_W-1]};
      diff    = trial - {1'b0, divisor};
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = STEP_W'(QUO_W);
         rem_in  = dividend[QUO_W+DEN_W-1:QUO_W];
         quo_in  = dividend[QUO_W-1:0];
      end else if (busy_ff) begin
         if (trial >= {1'b0, divisor}) begin
            rem_in = diff[DEN_W-1:0];
            quo_in = {quo_ff[QUO_W-2:0], 1'b1};
         end else begin
            rem_in = trial[DEN_W-1:0];
            quo_in = {quo_ff[QUO_W-2:0], 1'b0};
         end
         step_in = step_ff - STEP_W'(1);
         if (step_ff == STEP_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

### sv/ring_average_nonzero_core_chk.sv
// ----------------------------------------------------------------------------
// ring_average_nonzero_core_chk - port level checks
// One transfer in, one result out, never overlapping.
// ----------------------------------------------------------------------------
module ring_average_nonzero_core_chk (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_ready,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input logic [rav_pkg::SAMPLE_W-1:0] rsp_average
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_average))
      else $error("result changed while stalled");

   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("input taken while an item is in work");

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |-> !rsp_valid)
      else $error("input taken with a result pending");

   a_single_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready |=> !rsp_valid)
      else $error("result repeated");

   a_reset_quiet: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result shown out of reset");

endmodule

bind ring_average_nonzero_core ring_average_nonzero_core_chk u_chk (.*);
